// ===== rtl/core/rra_pkg.sv =====
// Shared types, codes and constants for the rectangle region allocator.
// No dependencies; every other file of the block except rra_ram imports this package.
package rra_pkg;

  localparam int MAX_FREE_BLOCKS_DEF = 64;
  localparam int COORD_BITS_DEF      = 16;
  localparam int IN_W                = 16;  // width of input and result coordinates
  localparam int PAD_W               = 8;
  localparam int ALIGN_W             = 11;
  localparam int SZ_W                = 17;  // padded and aligned size
  localparam int CFG_IDX_W           = 3;
  localparam int CFG_DATA_W          = 16;
  localparam logic [IN_W-1:0] REGION_RST = 16'd4096;
  localparam logic [ALIGN_W-1:0] ALIGN_RST = 11'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_PAD_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_W = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_H = 3'd5;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_FULL     = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_DIV_X, OP_CAP_X, OP_DIV_Y, OP_CAP_Y, OP_MUL,
    OP_COPY_INIT, OP_COPY_RD, OP_COPY_WR, OP_IDX_CLR, OP_SCAN_RD, OP_SCAN_EV,
    OP_SCAN_CMP, OP_SEL_BEST, OP_REM_RD, OP_REM_WR, OP_SPLIT, OP_LOAD_FREE,
    OP_INS_RD, OP_INS_EV, OP_APPEND, OP_LOAD_R2, OP_FINISH
  } op_t;

  typedef enum logic [1:0] {
    RET_EXACT,
    RET_SPLIT,
    RET_MERGE
  } ret_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DIVX, S_WX, S_DIVY, S_WY, S_MUL, S_CHK, S_CPRD, S_CPWR,
    S_SCRD, S_SCEV, S_SCCMP, S_SCEND, S_RMRD, S_RMWR, S_SPLIT, S_INS_CHK,
    S_INRD, S_INEV, S_APP, S_INS_DONE, S_OK, S_DONE
  } state_t;

  typedef struct packed {
    op_t     op;
    status_t st;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic ovf;
    logic copy_end;
    logic scan_end;
    logic exact;
    logic found;
    logic merged;
    logic b_zero;
    logic full;
    logic pend2;
    logic mode;
  } dp_stat_t;

endpackage

// ===== rtl/core/rra_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rra_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/rra_div.sv =====
// Restoring remainder unit, one quotient bit per cycle, used for size alignment.
// Depends on rra_pkg.
module rra_div
  import rra_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [SZ_W-1:0]    dividend,
  input  logic [ALIGN_W-1:0] divisor,
  output logic               busy,
  output logic [ALIGN_W-1:0] rem
);

  localparam int CNT_W = $clog2(SZ_W + 1);

  logic [SZ_W-1:0]    dvd_r;
  logic [ALIGN_W-1:0] dsr_r;
  logic [ALIGN_W-1:0] rem_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [ALIGN_W:0]   trial;

  assign trial = {rem_r, dvd_r[SZ_W-1]};
  assign busy  = (cnt_r != '0);
  assign rem   = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
      cnt_r <= CNT_W'(SZ_W);
    end else if (busy) begin
      dvd_r <= {dvd_r[SZ_W-2:0], 1'b0};
      cnt_r <= cnt_r - 1'b1;
      if (trial >= {1'b0, dsr_r}) begin
        rem_r <= ALIGN_W'(trial - {1'b0, dsr_r});
      end else begin
        rem_r <= trial[ALIGN_W-1:0];
      end
    end
  end

endmodule

// ===== rtl/core/rra_ctrl.sv =====
// Sequencer of the allocator: walks align, copy, scan, remove and insert steps.
// Depends on rra_pkg; drives the datapath through cmd_t and reads dp_stat_t.
module rra_ctrl
  import rra_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  dp_stat_t stat,
  output cmd_t     cmd
);

  state_t  state_r, state_nxt;
  ret_t    ret_r, ret_nxt;
  status_t st_r, st_nxt;

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= RET_EXACT;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      st_r    <= st_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    st_nxt    = st_r;
    cmd.op    = OP_NONE;
    cmd.st    = st_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op    = OP_LATCH;
          state_nxt = S_DIVX;
        end
      end
      S_DIVX: begin
        cmd.op    = OP_DIV_X;
        state_nxt = S_WX;
      end
      S_WX: begin
        if (stat.div_done) begin
          cmd.op    = OP_CAP_X;
          state_nxt = S_DIVY;
        end
      end
      S_DIVY: begin
        cmd.op    = OP_DIV_Y;
        state_nxt = S_WY;
      end
      S_WY: begin
        if (stat.div_done) begin
          cmd.op    = OP_CAP_Y;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.op    = OP_MUL;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (stat.ovf) begin
          st_nxt    = ST_OVERFLOW;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = OP_COPY_INIT;
          state_nxt = S_CPRD;
        end
      end
      S_CPRD: begin
        if (stat.copy_end) begin
          if (stat.mode) begin
            cmd.op    = OP_LOAD_FREE;
            state_nxt = S_INS_CHK;
          end else begin
            cmd.op    = OP_IDX_CLR;
            state_nxt = S_SCRD;
          end
        end else begin
          cmd.op    = OP_COPY_RD;
          state_nxt = S_CPWR;
        end
      end
      S_CPWR: begin
        cmd.op    = OP_COPY_WR;
        state_nxt = S_CPRD;
      end
      S_SCRD: begin
        if (stat.scan_end) begin
          state_nxt = S_SCEND;
        end else begin
          cmd.op    = OP_SCAN_RD;
          state_nxt = S_SCEV;
        end
      end
      S_SCEV: begin
        cmd.op = OP_SCAN_EV;
        if (stat.exact) begin
          ret_nxt   = RET_EXACT;
          state_nxt = S_RMRD;
        end else begin
          state_nxt = S_SCCMP;
        end
      end
      S_SCCMP: begin
        cmd.op    = OP_SCAN_CMP;
        state_nxt = S_SCRD;
      end
      S_SCEND: begin
        if (!stat.found) begin
          st_nxt    = ST_NO_SPACE;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = OP_SEL_BEST;
          ret_nxt   = RET_SPLIT;
          state_nxt = S_RMRD;
        end
      end
      S_RMRD: begin
        cmd.op    = OP_REM_RD;
        state_nxt = S_RMWR;
      end
      S_RMWR: begin
        cmd.op = OP_REM_WR;
        unique case (ret_r)
          RET_EXACT: state_nxt = S_OK;
          RET_SPLIT: state_nxt = S_SPLIT;
          default:   state_nxt = S_INS_CHK;
        endcase
      end
      S_SPLIT: begin
        cmd.op    = OP_SPLIT;
        state_nxt = S_INS_CHK;
      end
      S_INS_CHK: begin
        cmd.op    = OP_IDX_CLR;
        state_nxt = stat.b_zero ? S_INS_DONE : S_INRD;
      end
      S_INRD: begin
        if (stat.scan_end) begin
          state_nxt = S_APP;
        end else begin
          cmd.op    = OP_INS_RD;
          state_nxt = S_INEV;
        end
      end
      S_INEV: begin
        cmd.op = OP_INS_EV;
        if (stat.merged) begin
          ret_nxt   = RET_MERGE;
          state_nxt = S_RMRD;
        end else begin
          state_nxt = S_INRD;
        end
      end
      S_APP: begin
        if (stat.full) begin
          st_nxt    = ST_FULL;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = OP_APPEND;
          state_nxt = S_INS_DONE;
        end
      end
      S_INS_DONE: begin
        if (stat.pend2) begin
          cmd.op    = OP_LOAD_R2;
          state_nxt = S_INS_CHK;
        end else begin
          state_nxt = S_OK;
        end
      end
      S_OK: begin
        st_nxt    = ST_OK;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.op    = OP_FINISH;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/rra_dp.sv =====
// Datapath: configuration registers, two-bank free list RAM, size alignment,
// best-fit scan, merge logic and result registers. Depends on rra_pkg,
// rra_ram and rra_div.
module rra_dp
  import rra_pkg::*;
#(
  parameter int MAX_FREE_BLOCKS = MAX_FREE_BLOCKS_DEF,
  parameter int COORD_BITS      = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output dp_stat_t              stat,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_mode,
  input  logic [IN_W-1:0]       in_req_pos_x,
  input  logic [IN_W-1:0]       in_req_pos_y,
  input  logic [IN_W-1:0]       in_req_width,
  input  logic [IN_W-1:0]       in_req_height,
  output logic                  out_valid,
  output logic [IN_W-1:0]       out_pos_x,
  output logic [IN_W-1:0]       out_pos_y,
  output logic [IN_W-1:0]       out_width,
  output logic [IN_W-1:0]       out_height,
  output logic [1:0]            out_status
);

  localparam int N    = MAX_FREE_BLOCKS;
  localparam int CB   = COORD_BITS;
  localparam int IW   = $clog2(N);
  localparam int CW   = $clog2(N + 1);
  localparam int AW   = IW + 1;
  localparam int EW   = 4 * CB;
  localparam int unsigned MASK = (1 << CB) - 1;

  // configuration
  logic [PAD_W-1:0]   pad_x_r, pad_y_r;
  logic [ALIGN_W-1:0] align_x_r, align_y_r;
  logic [IN_W-1:0]    region_w_r, region_h_r;

  // request and sizes
  logic            mode_r;
  logic [IN_W-1:0] rx_r, ry_r, rw_r, rh_r;
  logic [SZ_W-1:0] sx_r, sy_r;
  logic [2*CB-1:0] sxsy_r;

  // list state
  logic          bank_r;
  logic [CW-1:0] fc_r, wc_r, idx_r, rem_idx_r;

  // scan state
  logic [EW-1:0]   cand_r, best_e_r;
  logic            cand_ok_r, cand_tier_r;
  logic [2*CB-1:0] prod_r, best_waste_r;
  logic            found_r, best_tier_r;
  logic [CW-1:0]   best_idx_r;
  logic [CB-1:0]   px_r, py_r;

  // block under insert and second split piece
  logic [CB-1:0] bx_r, by_r, bw_r, bh_r;
  logic [EW-1:0] r2_r;
  logic          pend2_r;

  // RAM ports
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  // divider
  logic               div_start, div_busy;
  logic [SZ_W-1:0]    div_dvd;
  logic [ALIGN_W-1:0] div_dsr, div_rem;

  rra_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .busy     (div_busy),
    .rem      (div_rem)
  );

  rra_ram #(.WIDTH(EW), .DEPTH(2 * N)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  function automatic logic [CB-1:0] sat(input logic [IN_W-1:0] v);
    return (32'(v) > MASK) ? CB'(MASK) : CB'(v);
  endfunction

  // entry read from the RAM
  logic [CB-1:0] e_x, e_y, e_w, e_h;
  assign e_x = ram_rdata[4*CB-1:3*CB];
  assign e_y = ram_rdata[3*CB-1:2*CB];
  assign e_w = ram_rdata[2*CB-1:CB];
  assign e_h = ram_rdata[CB-1:0];

  logic [CB-1:0] b_x, b_y, b_w, b_h;
  assign b_x = best_e_r[4*CB-1:3*CB];
  assign b_y = best_e_r[3*CB-1:2*CB];
  assign b_w = best_e_r[2*CB-1:CB];
  assign b_h = best_e_r[CB-1:0];

  logic [CB-1:0] sxc, syc;
  assign sxc = sx_r[CB-1:0];
  assign syc = sy_r[CB-1:0];

  // padded sizes and aligned sizes
  logic [SZ_W-1:0] s_x, s_y, al_x, al_y;
  assign s_x  = SZ_W'(rw_r) + SZ_W'({pad_x_r, 1'b0});
  assign s_y  = SZ_W'(rh_r) + SZ_W'({pad_y_r, 1'b0});
  assign al_x = (align_x_r > ALIGN_W'(1) && div_rem != '0) ?
                s_x + SZ_W'(align_x_r) - SZ_W'(div_rem) : s_x;
  assign al_y = (align_y_r > ALIGN_W'(1) && div_rem != '0) ?
                s_y + SZ_W'(align_y_r) - SZ_W'(div_rem) : s_y;

  // freed block position and range checks
  logic [IN_W-1:0] fx, fy;
  logic [IN_W+1:0] fx_end, fy_end;
  logic            ovf;
  assign fx     = rx_r - IN_W'(pad_x_r);
  assign fy     = ry_r - IN_W'(pad_y_r);
  assign fx_end = (IN_W+2)'(fx) + (IN_W+2)'(sx_r);
  assign fy_end = (IN_W+2)'(fy) + (IN_W+2)'(sy_r);
  assign ovf    = (32'(sx_r) > MASK) || (32'(sy_r) > MASK) ||
                  (mode_r && ((rx_r < IN_W'(pad_x_r)) || (ry_r < IN_W'(pad_y_r)) ||
                              (32'(fx_end) > MASK + 1) || (32'(fy_end) > MASK + 1)));

  // scan classification
  logic exact, tier0, tier1;
  assign exact = (e_w == sxc) && (e_h == syc);
  assign tier0 = ((e_w == sxc) && (e_h >= syc)) || ((e_h == syc) && (e_w >= sxc));
  assign tier1 = (e_w > sxc) && (e_h > syc);

  logic [2*CB-1:0] waste;
  logic            better;
  assign waste  = prod_r - sxsy_r;
  assign better = cand_ok_r && (!found_r || (cand_tier_r < best_tier_r) ||
                  ((cand_tier_r == best_tier_r) && (waste < best_waste_r)));

  // merge test against the block under insert
  logic [CB:0] sum_h, sum_w, e_yend, b_yend, e_xend, b_xend;
  logic        v_ok, v_up, v_dn, h_ok, h_lf, h_rt, vert, horz, merged;
  assign sum_h  = {1'b0, e_h} + {1'b0, bh_r};
  assign sum_w  = {1'b0, e_w} + {1'b0, bw_r};
  assign e_yend = {1'b0, e_y} + {1'b0, e_h};
  assign b_yend = {1'b0, by_r} + {1'b0, bh_r};
  assign e_xend = {1'b0, e_x} + {1'b0, e_w};
  assign b_xend = {1'b0, bx_r} + {1'b0, bw_r};
  assign v_ok   = (e_w == bw_r) && (e_x == bx_r) && (32'(sum_h) <= MASK);
  assign v_up   = (e_yend == {1'b0, by_r});
  assign v_dn   = (b_yend == {1'b0, e_y});
  assign h_ok   = (e_h == bh_r) && (e_y == by_r) && (32'(sum_w) <= MASK);
  assign h_lf   = (e_xend == {1'b0, bx_r});
  assign h_rt   = (b_xend == {1'b0, e_x});
  assign vert   = v_ok && (v_up || v_dn);
  assign horz   = !vert && h_ok && (h_lf || h_rt);
  assign merged = vert || horz;

  // region after a configuration write
  logic [IN_W-1:0] new_rw, new_rh;
  logic            region_wr;
  assign region_wr = cfg_we && ((cfg_idx == CFG_REGION_W) || (cfg_idx == CFG_REGION_H));
  assign new_rw    = (cfg_idx == CFG_REGION_W) ? cfg_wdata : region_w_r;
  assign new_rh    = (cfg_idx == CFG_REGION_H) ? cfg_wdata : region_h_r;

  assign stat.div_done = !div_busy;
  assign stat.ovf      = ovf;
  assign stat.copy_end = (idx_r == fc_r);
  assign stat.scan_end = (idx_r == wc_r);
  assign stat.exact    = exact;
  assign stat.found    = found_r;
  assign stat.merged   = merged;
  assign stat.b_zero   = (bw_r == '0) || (bh_r == '0);
  assign stat.full     = (32'(wc_r) >= N);
  assign stat.pend2    = pend2_r;
  assign stat.mode     = mode_r;

  assign div_start = (cmd.op == OP_DIV_X) || (cmd.op == OP_DIV_Y);
  assign div_dvd   = (cmd.op == OP_DIV_Y) ? s_y : s_x;
  assign div_dsr   = (cmd.op == OP_DIV_Y) ? align_y_r : align_x_r;

  // RAM port control; work bank is the one not committed
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {~bank_r, idx_r[IW-1:0]};
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = {~bank_r, idx_r[IW-1:0]};
    if (!rst_n) begin
      ram_we    = 1'b1;
      ram_waddr = '0;
      ram_wdata = {CB'(0), CB'(0), sat(REGION_RST), sat(REGION_RST)};
    end else if (region_wr) begin
      ram_we    = 1'b1;
      ram_waddr = {bank_r, IW'(0)};
      ram_wdata = {CB'(0), CB'(0), sat(new_rw), sat(new_rh)};
    end else begin
      unique case (cmd.op)
        OP_COPY_RD: begin
          ram_re    = 1'b1;
          ram_raddr = {bank_r, idx_r[IW-1:0]};
        end
        OP_COPY_WR: ram_we = 1'b1;
        OP_SCAN_RD, OP_INS_RD: ram_re = 1'b1;
        OP_REM_RD: begin
          ram_re    = 1'b1;
          ram_raddr = {~bank_r, IW'(wc_r - 1'b1)};
        end
        OP_REM_WR: begin
          ram_we    = 1'b1;
          ram_waddr = {~bank_r, rem_idx_r[IW-1:0]};
        end
        OP_APPEND: begin
          ram_we    = 1'b1;
          ram_waddr = {~bank_r, wc_r[IW-1:0]};
          ram_wdata = {bx_r, by_r, bw_r, bh_r};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_x_r    <= '0;
      pad_y_r    <= '0;
      align_x_r  <= ALIGN_RST;
      align_y_r  <= ALIGN_RST;
      region_w_r <= REGION_RST;
      region_h_r <= REGION_RST;
      bank_r     <= 1'b0;
      fc_r       <= CW'((sat(REGION_RST) != '0) ? 1 : 0);
      wc_r       <= '0;
      idx_r      <= '0;
      found_r    <= 1'b0;
      pend2_r    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_PAD_X:    pad_x_r    <= cfg_wdata[PAD_W-1:0];
          CFG_PAD_Y:    pad_y_r    <= cfg_wdata[PAD_W-1:0];
          CFG_ALIGN_X:  align_x_r  <= cfg_wdata[ALIGN_W-1:0];
          CFG_ALIGN_Y:  align_y_r  <= cfg_wdata[ALIGN_W-1:0];
          CFG_REGION_W: region_w_r <= cfg_wdata;
          CFG_REGION_H: region_h_r <= cfg_wdata;
          default: ;
        endcase
        if (region_wr) begin
          fc_r <= CW'((sat(new_rw) != '0 && sat(new_rh) != '0) ? 1 : 0);
        end
      end
      unique case (cmd.op)
        OP_LATCH: begin
          mode_r  <= in_mode;
          rx_r    <= in_req_pos_x;
          ry_r    <= in_req_pos_y;
          rw_r    <= in_req_width;
          rh_r    <= in_req_height;
          pend2_r <= 1'b0;
        end
        OP_CAP_X: sx_r <= al_x;
        OP_CAP_Y: sy_r <= al_y;
        OP_MUL:   sxsy_r <= sxc * syc;
        OP_COPY_INIT: begin
          idx_r <= '0;
          wc_r  <= fc_r;
        end
        OP_COPY_WR: idx_r <= idx_r + 1'b1;
        OP_IDX_CLR: begin
          idx_r   <= '0;
          found_r <= 1'b0;
        end
        OP_SCAN_EV: begin
          cand_r      <= ram_rdata;
          cand_ok_r   <= tier0 || tier1;
          cand_tier_r <= !tier0;
          prod_r      <= e_w * e_h;
          if (exact) begin
            rem_idx_r <= idx_r;
            px_r      <= e_x;
            py_r      <= e_y;
          end
        end
        OP_SCAN_CMP: begin
          if (better) begin
            found_r      <= 1'b1;
            best_idx_r   <= idx_r;
            best_tier_r  <= cand_tier_r;
            best_waste_r <= waste;
            best_e_r     <= cand_r;
          end
          idx_r <= idx_r + 1'b1;
        end
        OP_SEL_BEST: rem_idx_r <= best_idx_r;
        OP_REM_WR:   wc_r <= wc_r - 1'b1;
        OP_SPLIT: begin
          px_r <= b_x;
          py_r <= b_y;
          if (!best_tier_r) begin
            if (b_w == sxc) begin
              {bx_r, by_r, bw_r, bh_r} <= {b_x, b_y + syc, b_w, b_h - syc};
            end else begin
              {bx_r, by_r, bw_r, bh_r} <= {b_x + sxc, b_y, b_w - sxc, b_h};
            end
          end else begin
            {bx_r, by_r, bw_r, bh_r} <= {b_x + sxc, b_y, b_w - sxc, syc};
            r2_r    <= {b_x, b_y + syc, b_w, b_h - syc};
            pend2_r <= 1'b1;
          end
        end
        OP_LOAD_FREE: begin
          {bx_r, by_r, bw_r, bh_r} <= {fx[CB-1:0], fy[CB-1:0], sxc, syc};
        end
        OP_INS_EV: begin
          if (vert) begin
            bh_r <= sum_h[CB-1:0];
            if (v_up) begin
              by_r <= e_y;
            end
          end else if (horz) begin
            bw_r <= sum_w[CB-1:0];
            if (h_lf) begin
              bx_r <= e_x;
            end
          end
          if (merged) begin
            rem_idx_r <= idx_r;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        OP_APPEND: wc_r <= wc_r + 1'b1;
        OP_LOAD_R2: begin
          {bx_r, by_r, bw_r, bh_r} <= r2_r;
          pend2_r <= 1'b0;
        end
        OP_FINISH: begin
          out_valid  <= 1'b1;
          out_status <= cmd.st;
          out_pos_x  <= '0;
          out_pos_y  <= '0;
          out_width  <= '0;
          out_height <= '0;
          if (cmd.st == ST_OK) begin
            // commit the work bank
            bank_r <= ~bank_r;
            fc_r   <= wc_r;
            if (!mode_r) begin
              out_pos_x  <= IN_W'(px_r) + IN_W'(pad_x_r);
              out_pos_y  <= IN_W'(py_r) + IN_W'(pad_y_r);
              out_width  <= rw_r;
              out_height <= rh_r;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/rect_region_allocator.sv =====
// Top level of the rectangle region allocator: controller plus datapath.
// Depends on rra_pkg, rra_ctrl and rra_dp.
//
//  channel  handshake        payload
//  input    start / busy     in_mode, in_req_pos_x/y, in_req_width/height
//  result   out_valid        out_pos_x/y, out_width, out_height, out_status
//  config   cfg_we           cfg_idx, cfg_wdata
//
// One item at a time. An item goes through alignment (one bit a cycle in the
// remainder unit, plus launch and capture), a copy of the free entries into
// the work bank, a scan of the entries on allocate, and on each insert a
// visit of the entries plus a removal per merge, where merges restart the
// scan, so the worst case grows with the square of the list depth (single
// RAM port).
// Reset is synchronous and loads the whole region as the only free entry.
// The result strobe lasts one cycle; the receiver cannot stall it.
module rect_region_allocator
  import rra_pkg::*;
#(
  parameter int MAX_FREE_BLOCKS = MAX_FREE_BLOCKS_DEF,
  parameter int COORD_BITS      = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_mode,
  input  logic [IN_W-1:0]       in_req_pos_x,
  input  logic [IN_W-1:0]       in_req_pos_y,
  input  logic [IN_W-1:0]       in_req_width,
  input  logic [IN_W-1:0]       in_req_height,
  output logic                  out_valid,
  output logic [IN_W-1:0]       out_pos_x,
  output logic [IN_W-1:0]       out_pos_y,
  output logic [IN_W-1:0]       out_width,
  output logic [IN_W-1:0]       out_height,
  output logic [1:0]            out_status,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cmd_t     cmd;
  dp_stat_t stat;

  rra_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  rra_dp #(
    .MAX_FREE_BLOCKS (MAX_FREE_BLOCKS),
    .COORD_BITS      (COORD_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .in_mode       (in_mode),
    .in_req_pos_x  (in_req_pos_x),
    .in_req_pos_y  (in_req_pos_y),
    .in_req_width  (in_req_width),
    .in_req_height (in_req_height),
    .out_valid     (out_valid),
    .out_pos_x     (out_pos_x),
    .out_pos_y     (out_pos_y),
    .out_width     (out_width),
    .out_height    (out_height),
    .out_status    (out_status)
  );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for rect_region_allocator: directed and random
// allocate/free beats across several configurations, with a built-in predictor.
// Depends on rra_pkg and the rect_region_allocator RTL.
module testbench
  import rra_pkg::*;
();

  localparam int          DEPTH = 64;
  localparam int unsigned CMASK = 32'hFFFF;

  typedef struct {
    int unsigned x, y, w, h;
  } rect_t;

  typedef struct {
    bit         mode;
    bit [15:0]  px, py, w, h;
  } req_t;

  typedef struct {
    bit [15:0] px, py, w, h;
    status_t   st;
  } res_t;

  class alloc_scoreboard;
    rect_t       blocks[DEPTH];
    int unsigned nblocks;
    rect_t       work[DEPTH];
    int unsigned nwork;
    int unsigned pad_x, pad_y, align_x, align_y, reg_w, reg_h;
    res_t        expected_q[$];
    int          errors;

    function void reset_state();
      pad_x = 0; pad_y = 0; align_x = 1; align_y = 1;
      reg_w = 4096; reg_h = 4096;
      load_region();
    endfunction

    function void load_region();
      nblocks = 0;
      if (reg_w != 0 && reg_h != 0) begin
        blocks[0] = '{0, 0, reg_w, reg_h};
        nblocks = 1;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
      case (idx)
        CFG_PAD_X:    pad_x = val & 32'hFF;
        CFG_PAD_Y:    pad_y = val & 32'hFF;
        CFG_ALIGN_X:  align_x = val & 32'h7FF;
        CFG_ALIGN_Y:  align_y = val & 32'h7FF;
        CFG_REGION_W: begin reg_w = val & CMASK; load_region(); end
        CFG_REGION_H: begin reg_h = val & CMASK; load_region(); end
        default: ;
      endcase
    endfunction

    function int unsigned padded(int unsigned size, int unsigned pad, int unsigned al);
      int unsigned s;
      s = size + 2 * pad;
      if (al > 1) s = ((s + al - 1) / al) * al;
      return s;
    endfunction

    function void drop(int unsigned i);
      work[i] = work[nwork - 1];
      nwork--;
    endfunction

    // Merge b with edge-sharing neighbors, rescanning after each merge.
    function bit insert(rect_t b);
      int unsigned i;
      rect_t       e;
      bit          merged;
      i = 0;
      if (b.w == 0 || b.h == 0) return 1;
      while (i < nwork) begin
        e = work[i];
        merged = 0;
        if (e.w == b.w && e.x == b.x && e.h + b.h <= CMASK) begin
          if (e.y + e.h == b.y) begin
            b.y = e.y; b.h += e.h; merged = 1;
          end else if (b.y + b.h == e.y) begin
            b.h += e.h; merged = 1;
          end
        end
        if (!merged && e.h == b.h && e.y == b.y && e.w + b.w <= CMASK) begin
          if (e.x + e.w == b.x) begin
            b.x = e.x; b.w += e.w; merged = 1;
          end else if (b.x + b.w == e.x) begin
            b.w += e.w; merged = 1;
          end
        end
        if (merged) begin
          drop(i);
          i = 0;
        end else begin
          i++;
        end
      end
      if (nwork >= DEPTH) return 0;
      work[nwork++] = b;
      return 1;
    endfunction

    function status_t place(int unsigned sx, int unsigned sy,
                            output int unsigned px, output int unsigned py);
      int unsigned     best, tier, best_tier;
      longint unsigned waste, best_waste;
      bit              found;
      rect_t           e, r1, r2;
      best = 0; best_tier = 2; best_waste = 0; found = 0;
      px = 0; py = 0;
      for (int unsigned i = 0; i < nwork; i++) begin
        e = work[i];
        if (e.w == sx && e.h == sy) begin
          drop(i);
          px = e.x; py = e.y;
          return ST_OK;
        end
        if ((e.w == sx && e.h >= sy) || (e.h == sy && e.w >= sx)) tier = 0;
        else if (e.w > sx && e.h > sy) tier = 1;
        else continue;
        waste = longint'(e.w) * e.h - longint'(sx) * sy;
        if (!found || tier < best_tier || (tier == best_tier && waste < best_waste)) begin
          found = 1; best = i; best_tier = tier; best_waste = waste;
        end
      end
      if (!found) return ST_NO_SPACE;
      e = work[best];
      drop(best);
      if (best_tier == 0) begin
        if (e.w == sx) r1 = '{e.x, e.y + sy, e.w, e.h - sy};
        else r1 = '{e.x + sx, e.y, e.w - sx, e.h};
        if (!insert(r1)) return ST_FULL;
      end else begin
        r1 = '{e.x + sx, e.y, e.w - sx, sy};
        r2 = '{e.x, e.y + sy, e.w, e.h - sy};
        if (!insert(r1)) return ST_FULL;
        if (!insert(r2)) return ST_FULL;
      end
      px = e.x; py = e.y;
      return ST_OK;
    endfunction

    // Predict the result of an accepted beat and queue it.
    function res_t note_item(req_t r);
      int unsigned sx, sy, px, py;
      res_t        res;
      rect_t       b;
      sx = padded(r.w, pad_x, align_x);
      sy = padded(r.h, pad_y, align_y);
      res = '{0, 0, 0, 0, ST_OK};
      work = blocks;
      nwork = nblocks;
      if (sx > CMASK || sy > CMASK) begin
        res.st = ST_OVERFLOW;
      end else if (!r.mode) begin
        res.st = place(sx, sy, px, py);
        if (res.st == ST_OK) begin
          res.px = 16'(px + pad_x);
          res.py = 16'(py + pad_y);
          res.w = r.w;
          res.h = r.h;
        end
      end else if (r.px < pad_x || r.py < pad_y) begin
        res.st = ST_OVERFLOW;
      end else begin
        b = '{r.px - pad_x, r.py - pad_y, sx, sy};
        if (b.x + b.w > CMASK + 1 || b.y + b.h > CMASK + 1) res.st = ST_OVERFLOW;
        else if (!insert(b)) res.st = ST_FULL;
      end
      if (res.st == ST_OK) begin
        blocks = work;
        nblocks = nwork;
      end
      expected_q.insert(expected_q.size(), res);
      return res;
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    task check(res_t got);
      res_t exp;
      if (expected_q.size() == 0) begin
        report_mismatch("result with no request pending");
        return;
      end
      exp = expected_q.pop_front();
      if (got.st != exp.st)
        report_mismatch($sformatf("status %0d, expected %0d", got.st, exp.st));
      if (got.px != exp.px)
        report_mismatch($sformatf("pos_x %0d, expected %0d", got.px, exp.px));
      if (got.py != exp.py)
        report_mismatch($sformatf("pos_y %0d, expected %0d", got.py, exp.py));
      if (got.w != exp.w)
        report_mismatch($sformatf("width %0d, expected %0d", got.w, exp.w));
      if (got.h != exp.h)
        report_mismatch($sformatf("height %0d, expected %0d", got.h, exp.h));
    endtask
  endclass

  logic                  clk = 0;
  logic                  rst_n = 0;
  logic                  start = 0;
  logic                  busy;
  logic                  in_mode = 0;
  logic [IN_W-1:0]       in_req_pos_x = '0, in_req_pos_y = '0;
  logic [IN_W-1:0]       in_req_width = 16'd1, in_req_height = 16'd1;
  logic                  out_valid;
  logic [IN_W-1:0]       out_pos_x, out_pos_y, out_width, out_height;
  logic [1:0]            out_status;
  logic                  cfg_we = 0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  alloc_scoreboard book = new();
  rect_t           live_q[$];   // allocations currently held, candidates to free
  int              idle_pct;

  rect_region_allocator DUT (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid)
      book.check(res_t'{out_pos_x, out_pos_y, out_width, out_height,
                        status_t'(out_status)});
  end

  initial begin
    #(12 * 150000000);
    $display("Mismatches found");
    $finish;
  end

  task automatic send(req_t r);
    res_t res;
    in_mode <= r.mode;
    in_req_pos_x <= r.px;
    in_req_pos_y <= r.py;
    in_req_width <= r.w;
    in_req_height <= r.h;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    res = book.note_item(r);
    if (!r.mode && res.st == ST_OK)
      live_q.insert(live_q.size(), rect_t'{res.px, res.py, r.w, r.h});
    // Hold off the next beat at random.
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic send_fields(bit m, int px, int py, int w, int h);
    send('{m, 16'(px), 16'(py), 16'(w), 16'(h)});
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (book.expected_q.size() != 0 || busy) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  // Leave the write enable high; the caller drops it after the last write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= 16'(val);
    @(posedge clk);
    book.write_reg(idx, val);
  endtask

  task automatic setup(int px, int py, int ax, int ay, int rw, int rh);
    write_reg(CFG_PAD_X, px);
    write_reg(CFG_PAD_Y, py);
    write_reg(CFG_ALIGN_X, ax);
    write_reg(CFG_ALIGN_Y, ay);
    write_reg(CFG_REGION_W, rw);
    write_reg(CFG_REGION_H, rh);
    cfg_we <= 1'b0;
    live_q.delete();
    @(posedge clk);
  endtask

  task automatic random_items(int count);
    int    sel, k, wmax, hmax;
    rect_t v;
    wmax = book.reg_w / 6 + 1;
    hmax = book.reg_h / 6 + 1;
    repeat (count) begin
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        send('{1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
               16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535))});
      end else if (sel < 45 && live_q.size() != 0) begin
        k = $urandom_range(0, live_q.size() - 1);
        v = live_q[k];
        live_q.delete(k);
        send_fields(1, v.x, v.y, v.w, v.h);
      end else begin
        send_fields(0, 0, 0, $urandom_range(1, wmax > 65535 ? 65535 : wmax),
                    $urandom_range(1, hmax > 65535 ? 65535 : hmax));
      end
    end
    drain();
  endtask

  initial begin
    book.reset_state();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: exact fit, overflow, out of space, freeing back, field extremes.
    idle_pct = 0;
    send_fields(0, 0, 0, 4096, 4096);
    send_fields(0, 0, 0, 1, 1);
    send_fields(1, 0, 0, 4096, 4096);
    send_fields(0, 0, 0, 1, 1);
    send_fields(0, 0, 0, 65535, 65535);
    send_fields(1, 65535, 65535, 65535, 65535);
    send_fields(1, 65535, 0, 1, 1);
    send_fields(1, 65534, 0, 2, 1);
    send_fields(0, 0, 0, 4095, 1);
    send_fields(0, 0, 0, 1, 4095);
    send_fields(1, 1, 0, 4095, 1);
    send_fields(1, 0, 1, 1, 4095);
    send_fields(0, 0, 0, 4096, 1);
    drain();
    setup(255, 255, 1024, 1024, 65535, 65535);
    send_fields(1, 0, 0, 1, 1);
    send_fields(0, 0, 0, 65535, 1);
    send_fields(0, 0, 0, 1, 1);
    send_fields(1, 255, 255, 1, 1);
    drain();
    setup(0, 0, 0, 0, 1, 1);
    send_fields(0, 0, 0, 1, 1);
    send_fields(0, 0, 0, 1, 1);
    send_fields(1, 0, 0, 1, 1);
    send_fields(0, 0, 0, 2, 1);
    drain();

    setup(0, 0, 1, 1, 4096, 4096);
    idle_pct = 46;
    random_items(290);
    setup(255, 255, 1024, 1024, 65535, 65535);
    idle_pct = 17;
    random_items(290);
    setup(3, 0, 0, 0, 200, 1);
    idle_pct = 0;
    random_items(290);
    for (int p = 0; p < 3; p++) begin
      setup($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 16),
            $urandom_range(0, 16), $urandom_range(1000, 5000), $urandom_range(1000, 5000));
      idle_pct = (p == 1) ? 46 : 17;
      random_items(290);
    end

    if (book.errors == 0 && book.expected_q.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/core/rra_pkg.sv
rtl/core/rra_ram.sv
rtl/core/rra_div.sv
rtl/core/rra_ctrl.sv
rtl/core/rra_dp.sv
rtl/core/rect_region_allocator.sv
tb/testbench.sv
